@@ rtl/ldi_pkg.sv @@
`default_nettype none
package ldi_pkg;

   localparam int MAX_ITERATIONS = 30;
   localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);

   localparam int NUM_W     = 57;
   localparam int DEN_W     = 32;
   localparam int DIV_CNT_W = $clog2(NUM_W);

   localparam int CSR_AW = 6;
   localparam int CSR_DW = 64;

   localparam logic [2:0] REG_CENTER_U  = 3'd0;
   localparam logic [2:0] REG_CENTER_V  = 3'd1;
   localparam logic [2:0] REG_SCALE_M   = 3'd2;
   localparam logic [2:0] REG_RADIAL_K12 = 3'd3;
   localparam logic [2:0] REG_RADIAL_K3 = 3'd4;
   localparam logic [2:0] REG_TANG_P12  = 3'd5;
   localparam logic [2:0] REG_PRISM_S12 = 3'd6;
   localparam logic [2:0] REG_PRISM_S34 = 3'd7;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } ldi_div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quo;
   } ldi_div_rsp_type;

endpackage
`default_nettype wire

@@ rtl/ldi_if.sv @@
`default_nettype none
interface ldi_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] u_coord;
   logic [23:0] v_coord;
   logic        last_point;

   modport source (output valid, output u_coord, output v_coord, output last_point,
                   input ready);
   modport sink   (input valid, input u_coord, input v_coord, input last_point,
                   output ready);
endinterface

interface ldi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [24:0] undist_u;
   logic signed [24:0] undist_v;
   logic               last_out;
   logic               saturated;

   modport source (output valid, output undist_u, output undist_v, output last_out,
                   output saturated, input ready);
   modport sink   (input valid, input undist_u, input undist_v, input last_out,
                   input saturated, output ready);
endinterface
`default_nettype wire

@@ rtl/ldi_div.sv @@
`default_nettype none
module ldi_div (
   input  logic                     clock,
   input  logic                     reset,
   input  ldi_pkg::ldi_div_req_type div_req,
   output ldi_pkg::ldi_div_rsp_type div_rsp
);
   import ldi_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0]     quo_ff;
   logic [DEN_W-1:0]     rem_ff;
   logic [DEN_W-1:0]     den_ff;
   logic [DEN_W:0]       trial;
   logic [DEN_W:0]       sub;
   logic                 fits;
   logic [DEN_W-1:0]     rem_in;

   // one restoring step per cycle, numerator shifted out msb first
   always_comb begin
      trial  = {rem_ff, quo_ff[NUM_W-1]};
      sub    = trial - {1'b0, den_ff};
      fits   = trial >= {1'b0, den_ff};
      rem_in = fits ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            quo_ff  <= div_req.num;
            rem_ff  <= '0;
            den_ff  <= div_req.den;
         end else if (busy_ff) begin
            quo_ff <= {quo_ff[NUM_W-2:0], fits};
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule
`default_nettype wire

@@ rtl/lens_distortion_inverse.sv @@
`default_nettype none
// Inverse lens distortion: one distorted pixel point (Q16.8) per request transaction
// comes back as its undistorted position (signed Q17.8) in one response transaction.
// The point is normalized by the principal point and scale, then the radial,
// tangential and thin-prism model is inverted by fixed-point iteration, stopping
// after MAX_ITERATIONS passes or once a pass leaves both coordinates unchanged.
// All arithmetic runs on one 32x32 multiplier and one radix-2 divider under a
// small sequencer; the block takes one point at a time, and the two divisions of
// each pass dominate the time a point takes. A finished result sits in the output
// register and the next point is accepted while it waits. Registers are written
// over the csr port at byte address 8*index, 64-bit data; write only while idle.
module lens_distortion_inverse (
   input  logic                        clock,
   input  logic                        reset,
   ldi_req_if.sink                     req_ch,
   ldi_rsp_if.source                   rsp_ch,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ldi_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [ldi_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [ldi_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import ldi_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DIV_GO, S_DIV_WAIT, S_MUL, S_WB, S_PREP1, S_PREP2, S_CHECK, S_DONE
   } state_type;

   typedef enum logic [1:0] {DJ_NU, DJ_NV, DJ_X, DJ_Y} job_type;

   typedef enum logic [4:0] {
      ST_XX, ST_YY, ST_XY, ST_R4, ST_R6, ST_K1, ST_K2, ST_K3,
      ST_P1X, ST_P2X, ST_S1, ST_S2, ST_P1Y, ST_P2Y, ST_S3, ST_S4, ST_DU, ST_DV
   } step_type;

   localparam logic [31:0]        LIM    = 32'h7FFF_FFFF;
   localparam logic signed [35:0] LIM36  = 36'sd2147483647;
   localparam logic signed [35:0] NLIM36 = -36'sd2147483647;
   localparam logic signed [35:0] ONE36  = 36'sd16777216;
   localparam logic signed [34:0] OUT_HI = 35'sd16777215;
   localparam logic signed [34:0] OUT_LO = -35'sd16777216;

   function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
      if (v > LIM36) return 32'sh7FFF_FFFF;
      else if (v < NLIM36) return 32'sh8000_0001;
      else return v[31:0];
   endfunction

   function automatic logic ovf36(input logic signed [35:0] v);
      return (v > LIM36) || (v < NLIM36);
   endfunction

   function automatic logic signed [35:0] ext36(input logic signed [31:0] v);
      return {{4{v[31]}}, v};
   endfunction

   function automatic logic [31:0] abs32(input logic signed [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   // configuration registers
   logic [23:0] center_u_ff, center_v_ff;
   logic [31:0] scale_m_ff, radial_k3_ff;
   logic [63:0] radial_k12_ff, tang_p12_ff, prism_s12_ff, prism_s34_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_u_ff   <= '0;
         center_v_ff   <= '0;
         scale_m_ff    <= 32'd65536;
         radial_k12_ff <= '0;
         radial_k3_ff  <= '0;
         tang_p12_ff   <= '0;
         prism_s12_ff  <= '0;
         prism_s34_ff  <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[5:3])
            REG_CENTER_U:   center_u_ff   <= csr_pwdata[23:0];
            REG_CENTER_V:   center_v_ff   <= csr_pwdata[23:0];
            REG_SCALE_M:    scale_m_ff    <= csr_pwdata[31:0];
            REG_RADIAL_K12: radial_k12_ff <= csr_pwdata;
            REG_RADIAL_K3:  radial_k3_ff  <= csr_pwdata[31:0];
            REG_TANG_P12:   tang_p12_ff   <= csr_pwdata;
            REG_PRISM_S12:  prism_s12_ff  <= csr_pwdata;
            REG_PRISM_S34:  prism_s34_ff  <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[5:3])
         REG_CENTER_U:   csr_prdata = {40'd0, center_u_ff};
         REG_CENTER_V:   csr_prdata = {40'd0, center_v_ff};
         REG_SCALE_M:    csr_prdata = {32'd0, scale_m_ff};
         REG_RADIAL_K12: csr_prdata = radial_k12_ff;
         REG_RADIAL_K3:  csr_prdata = {32'd0, radial_k3_ff};
         REG_TANG_P12:   csr_prdata = tang_p12_ff;
         REG_PRISM_S12:  csr_prdata = prism_s12_ff;
         REG_PRISM_S34:  csr_prdata = prism_s34_ff;
         default:        csr_prdata = '0;
      endcase
   end

   logic signed [31:0] k1, k2, k3, p1, p2, s1, s2, s3, s4;
   assign k1 = radial_k12_ff[31:0];
   assign k2 = radial_k12_ff[63:32];
   assign k3 = radial_k3_ff;
   assign p1 = tang_p12_ff[31:0];
   assign p2 = tang_p12_ff[63:32];
   assign s1 = prism_s12_ff[31:0];
   assign s2 = prism_s12_ff[63:32];
   assign s3 = prism_s34_ff[31:0];
   assign s4 = prism_s34_ff[63:32];

   // sequencer and datapath registers
   state_type          state_ff;
   job_type            job_ff;
   step_type           step_ff;
   logic [ITER_W-1:0]  it_ff;
   logic               flag_ff;
   logic [23:0]        u_ff, v_ff;
   logic               last_ff;
   logic [31:0]        m_ff;
   logic signed [31:0] xd_ff, yd_ff, xn_ff, yn_ff, xnn_ff, ynn_ff;
   logic signed [31:0] xx_ff, yy_ff, xy_ff, r2_ff, r4_ff, r6_ff;
   logic signed [31:0] radial_ff, dx_ff, dy_ff, numx_ff, numy_ff;
   logic signed [35:0] acc_r_ff, acc_x_ff, acc_y_ff;
   logic signed [24:0] ou_ff, ov_ff;
   logic [63:0]        prod_ff;
   logic               neg_ff;
   logic               div_sign_ff;
   logic               rsp_valid_ff;
   logic signed [24:0] rsp_u_ff, rsp_v_ff;
   logic               rsp_last_ff, rsp_sat_ff;

   ldi_div_req_type div_req;
   ldi_div_rsp_type div_rsp;

   ldi_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // divider operands for the current job
   logic               div_sign;
   logic signed [24:0] diff_c;
   logic [24:0]        absd_c;
   logic [31:0]        absn_c, absr_c;
   logic signed [31:0] numsel_c;

   always_comb begin
      div_req.start = (state_ff == S_DIV_GO);
      diff_c   = (job_ff == DJ_NU) ? ($signed({1'b0, u_ff}) - $signed({1'b0, center_u_ff}))
                                   : ($signed({1'b0, v_ff}) - $signed({1'b0, center_v_ff}));
      absd_c   = diff_c[24] ? (~diff_c + 25'd1) : diff_c;
      numsel_c = (job_ff == DJ_X) ? numx_ff : numy_ff;
      absn_c   = abs32(numsel_c);
      absr_c   = abs32(radial_ff);
      unique case (job_ff)
         DJ_NU, DJ_NV: begin
            // (|diff| << 32 + m/2) / m
            div_req.num = {1'b0, absd_c[23:0], 32'd0} + {25'd0, 1'b0, m_ff[31:1]};
            div_req.den = m_ff;
            div_sign    = diff_c[24];
         end
         default: begin
            // (|num| << 24 + |radial|/2) / |radial|
            div_req.num = {2'd0, absn_c[30:0], 24'd0} + {25'd0, 1'b0, absr_c[31:1]};
            div_req.den = absr_c;
            div_sign    = numsel_c[31] ^ radial_ff[31];
         end
      endcase
   end

   // signed quotient, clamped
   logic               qovf_c;
   logic [31:0]        qmag_c;
   logic signed [31:0] qres_c;

   always_comb begin
      qovf_c = div_rsp.quo > NUM_W'(LIM);
      qmag_c = qovf_c ? LIM : div_rsp.quo[31:0];
      qres_c = div_sign_ff ? (~qmag_c + 32'd1) : qmag_c;
   end

   // multiplier operand select
   logic signed [32:0] op_a, op_b;
   logic signed [31:0] c2_c;
   logic               c2_ovf;
   logic signed [35:0] c2_sum;
   logic [32:0]        abs_a, abs_b;
   logic [63:0]        prod_c;

   always_comb begin
      // r2 + 2*xx for the x term, r2 + 2*yy for the y term
      c2_sum = (step_ff == ST_P2X) ? (ext36(r2_ff) + {{3{xx_ff[31]}}, xx_ff, 1'b0})
                                   : (ext36(r2_ff) + {{3{yy_ff[31]}}, yy_ff, 1'b0});
      c2_c   = sat36(c2_sum);
      c2_ovf = ovf36(c2_sum);
      op_a   = {k1[31], k1};
      op_b   = {r2_ff[31], r2_ff};
      unique case (step_ff)
         ST_XX:  begin op_a = {xn_ff[31], xn_ff}; op_b = {xn_ff[31], xn_ff}; end
         ST_YY:  begin op_a = {yn_ff[31], yn_ff}; op_b = {yn_ff[31], yn_ff}; end
         ST_XY:  begin op_a = {xn_ff[31], xn_ff}; op_b = {yn_ff[31], yn_ff}; end
         ST_R4:  begin op_a = {r2_ff[31], r2_ff}; op_b = {r2_ff[31], r2_ff}; end
         ST_R6:  begin op_a = {r4_ff[31], r4_ff}; op_b = {r2_ff[31], r2_ff}; end
         ST_K1:  begin op_a = {k1[31], k1}; op_b = {r2_ff[31], r2_ff}; end
         ST_K2:  begin op_a = {k2[31], k2}; op_b = {r4_ff[31], r4_ff}; end
         ST_K3:  begin op_a = {k3[31], k3}; op_b = {r6_ff[31], r6_ff}; end
         ST_P1X: begin op_a = {p1[31], p1}; op_b = {xy_ff[31], xy_ff}; end
         ST_P2X: begin op_a = {p2[31], p2}; op_b = {c2_c[31], c2_c}; end
         ST_S1:  begin op_a = {s1[31], s1}; op_b = {r2_ff[31], r2_ff}; end
         ST_S2:  begin op_a = {s2[31], s2}; op_b = {r4_ff[31], r4_ff}; end
         ST_P1Y: begin op_a = {p1[31], p1}; op_b = {c2_c[31], c2_c}; end
         ST_P2Y: begin op_a = {p2[31], p2}; op_b = {xy_ff[31], xy_ff}; end
         ST_S3:  begin op_a = {s3[31], s3}; op_b = {r2_ff[31], r2_ff}; end
         ST_S4:  begin op_a = {s4[31], s4}; op_b = {r4_ff[31], r4_ff}; end
         ST_DU:  begin op_a = {xn_ff[31], xn_ff}; op_b = {1'b0, m_ff}; end
         ST_DV:  begin op_a = {yn_ff[31], yn_ff}; op_b = {1'b0, m_ff}; end
         default: ;
      endcase
      abs_a  = op_a[32] ? (~op_a + 33'd1) : op_a;
      abs_b  = op_b[32] ? (~op_b + 33'd1) : op_b;
      prod_c = abs_a[31:0] * abs_b[31:0];
   end

   // rounding, clamp and sign of the registered product
   logic [63:0]        rnd_c;
   logic               movf_c;
   logic [32:0]        mag_c;
   logic signed [33:0] t_c;
   logic signed [35:0] t36_c, t2_c;
   logic signed [34:0] den_sum_c;
   logic signed [24:0] out_c;
   logic               out_ovf_c;

   always_comb begin
      case (step_ff) inside
         ST_XX, ST_YY, ST_XY, ST_R4, ST_R6: rnd_c = (prod_ff + (64'd1 << 23)) >> 24;
         ST_DU, ST_DV:                      rnd_c = (prod_ff + (64'd1 << 31)) >> 32;
         default:                           rnd_c = (prod_ff + (64'd1 << 29)) >> 30;
      endcase
      movf_c = rnd_c > 64'(LIM);
      if (step_ff == ST_DU || step_ff == ST_DV) mag_c = rnd_c[32:0];
      else mag_c = movf_c ? {1'b0, LIM} : {1'b0, rnd_c[31:0]};
      t_c   = neg_ff ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
      t36_c = {{2{t_c[33]}}, t_c};
      t2_c  = {t_c[33], t_c, 1'b0};
      den_sum_c = {t_c[33], t_c} + $signed({11'd0, (step_ff == ST_DU) ? center_u_ff
                                                                      : center_v_ff});
      out_ovf_c = (den_sum_c > OUT_HI) || (den_sum_c < OUT_LO);
      if (den_sum_c > OUT_HI) out_c = 25'sh0FF_FFFF;
      else if (den_sum_c < OUT_LO) out_c = 25'sh100_0000;
      else out_c = den_sum_c[24:0];
   end

   logic signed [31:0] radial_c;
   logic               req_acc;

   assign radial_c = sat36(acc_r_ff);
   assign req_acc  = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         job_ff       <= DJ_NU;
         step_ff      <= ST_XX;
         it_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         flag_ff      <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  u_ff     <= req_ch.u_coord;
                  v_ff     <= req_ch.v_coord;
                  last_ff  <= req_ch.last_point;
                  // zero scale runs as one lsb
                  m_ff     <= (scale_m_ff == 32'd0) ? 32'd1 : scale_m_ff;
                  flag_ff  <= (scale_m_ff == 32'd0);
                  job_ff   <= DJ_NU;
                  state_ff <= S_DIV_GO;
               end
            end
            S_DIV_GO: begin
               div_sign_ff <= div_sign;
               state_ff    <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_rsp.done) begin
                  if (qovf_c) flag_ff <= 1'b1;
                  unique case (job_ff)
                     DJ_NU: begin
                        xd_ff    <= qres_c;
                        xn_ff    <= qres_c;
                        job_ff   <= DJ_NV;
                        state_ff <= S_DIV_GO;
                     end
                     DJ_NV: begin
                        yd_ff    <= qres_c;
                        yn_ff    <= qres_c;
                        it_ff    <= '0;
                        step_ff  <= ST_XX;
                        state_ff <= S_MUL;
                     end
                     DJ_X: begin
                        xnn_ff   <= qres_c;
                        job_ff   <= DJ_Y;
                        state_ff <= S_DIV_GO;
                     end
                     default: begin
                        ynn_ff   <= qres_c;
                        state_ff <= S_CHECK;
                     end
                  endcase
               end
            end
            S_MUL: begin
               prod_ff  <= prod_c;
               neg_ff   <= op_a[32] ^ op_b[32];
               if ((step_ff == ST_P2X || step_ff == ST_P1Y) && c2_ovf) flag_ff <= 1'b1;
               state_ff <= S_WB;
            end
            S_WB: begin
               if (movf_c && step_ff != ST_DU && step_ff != ST_DV) flag_ff <= 1'b1;
               state_ff <= S_MUL;
               step_ff  <= step_type'(5'(step_ff) + 5'd1);
               unique case (step_ff)
                  ST_XX: xx_ff <= t_c[31:0];
                  ST_YY: yy_ff <= t_c[31:0];
                  ST_XY: begin
                     xy_ff <= t_c[31:0];
                     r2_ff <= sat36(ext36(xx_ff) + ext36(yy_ff));
                     if (ovf36(ext36(xx_ff) + ext36(yy_ff))) flag_ff <= 1'b1;
                  end
                  ST_R4:  r4_ff    <= t_c[31:0];
                  ST_R6:  r6_ff    <= t_c[31:0];
                  ST_K1:  acc_r_ff <= ONE36 + t36_c;
                  ST_K2, ST_K3: acc_r_ff <= acc_r_ff + t36_c;
                  ST_P1X: acc_x_ff <= t2_c;
                  ST_P2X, ST_S1: acc_x_ff <= acc_x_ff + t36_c;
                  ST_S2: begin
                     acc_x_ff <= acc_x_ff + t36_c;
                  end
                  ST_P1Y: acc_y_ff <= t36_c;
                  ST_P2Y: acc_y_ff <= acc_y_ff + t2_c;
                  ST_S3:  acc_y_ff <= acc_y_ff + t36_c;
                  ST_S4: begin
                     acc_y_ff <= acc_y_ff + t36_c;
                     state_ff <= S_PREP1;
                  end
                  ST_DU: begin
                     ou_ff <= out_c;
                     if (out_ovf_c) flag_ff <= 1'b1;
                  end
                  default: begin
                     ov_ff <= out_c;
                     if (out_ovf_c) flag_ff <= 1'b1;
                     state_ff <= S_DONE;
                  end
               endcase
            end
            S_PREP1: begin
               // zero divisor runs as plus one lsb
               radial_ff <= (radial_c == 32'sd0) ? 32'sd1 : radial_c;
               if (ovf36(acc_r_ff) || radial_c == 32'sd0 || ovf36(acc_x_ff) ||
                   ovf36(acc_y_ff)) flag_ff <= 1'b1;
               dx_ff    <= sat36(acc_x_ff);
               dy_ff    <= sat36(acc_y_ff);
               state_ff <= S_PREP2;
            end
            S_PREP2: begin
               numx_ff <= sat36(ext36(xd_ff) - ext36(dx_ff));
               numy_ff <= sat36(ext36(yd_ff) - ext36(dy_ff));
               if (ovf36(ext36(xd_ff) - ext36(dx_ff)) || ovf36(ext36(yd_ff) - ext36(dy_ff)))
                  flag_ff <= 1'b1;
               job_ff   <= DJ_X;
               state_ff <= S_DIV_GO;
            end
            S_CHECK: begin
               step_ff  <= ST_XX;
               state_ff <= S_MUL;
               if (xnn_ff == xn_ff && ynn_ff == yn_ff) begin
                  // converged, map back to pixels
                  step_ff <= ST_DU;
               end else begin
                  xn_ff <= xnn_ff;
                  yn_ff <= ynn_ff;
                  if (it_ff == ITER_W'(MAX_ITERATIONS - 1)) step_ff <= ST_DU;
                  else it_ff <= it_ff + ITER_W'(1);
               end
            end
            S_DONE: begin
               // output register must be free or emptying this cycle
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_u_ff     <= ou_ff;
                  rsp_v_ff     <= ov_ff;
                  rsp_last_ff  <= last_ff;
                  rsp_sat_ff   <= flag_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.undist_u  = rsp_u_ff;
   assign rsp_ch.undist_v  = rsp_v_ff;
   assign rsp_ch.last_out  = rsp_last_ff;
   assign rsp_ch.saturated = rsp_sat_ff;

   // pass counter stays inside the iteration budget
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      it_ff <= ITER_W'(MAX_ITERATIONS - 1))
      else $error("pass counter beyond budget");

   // divider reports only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_DIV_WAIT)
      else $error("divider done outside wait state");

   // an accepted transaction starts with the horizontal normalize
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff == S_DIV_GO && job_ff == DJ_NU)
      else $error("accepted point did not start normalize");

endmodule
`default_nettype wire
